// ===== sv/two_region_page_free_list_allocator_assert.svh =====
// Assertion macros used by the page allocator datapath.
`ifndef TWO_REGION_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define TWO_REGION_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define TPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define TPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/tpfa_pkg.sv =====
// Shared types and constants of the two-region page allocator.
`timescale 1ns / 1ps
package tpfa_pkg;

    localparam int ADDR_W     = 40;
    localparam int PAGE_SHIFT = 12;
    localparam int PW         = ADDR_W - PAGE_SHIFT;
    localparam int CNT_OUT_W  = 16;
    localparam int KP_W       = 11;

    localparam logic [PW-1:0]   PAGE_MAX       = '1;
    localparam logic [KP_W-1:0] KERN_PAGES_RST = 11'd1024;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALLOC_BEGIN = 2'd0;
    localparam logic [1:0] CFG_ALLOC_END   = 2'd1;
    localparam logic [1:0] CFG_KERN_PAGES  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OOM      = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_FULL     = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SIZE,
        S_FILL,
        S_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic size;
        logic fill;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_init;
        logic fill_done;
        logic out_free;
    } dp_sts_t;

    // Clamp a page bound to the page-number range.
    function automatic logic [PW-1:0] sat_page(input logic [PW+1:0] v);
        return (v > (PW+2)'(PAGE_MAX)) ? PAGE_MAX : v[PW-1:0];
    endfunction

endpackage

// ===== sv/tpfa_dp.sv =====
// Datapath of the page allocator: config, bounds, counts, stack memories, output register.
`timescale 1ns / 1ps
`include "two_region_page_free_list_allocator_assert.svh"
module tpfa_dp
    import tpfa_pkg::*;
#(
    parameter int KERN_DEPTH = 1024,
    parameter int USER_DEPTH = 32768
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_sts_t              sts,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic [1:0]           s_mode,
    input  logic                 s_in_kernel,
    input  logic [ADDR_W-1:0]    s_page_addr,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_result_addr,
    output logic [1:0]           m_status,
    output logic [CNT_OUT_W-1:0] m_free_count
);

    localparam int KCW = $clog2(KERN_DEPTH + 1);
    localparam int UCW = $clog2(USER_DEPTH + 1);
    localparam int KAW = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
    localparam int UAW = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
    localparam int FW  = (KCW > UCW) ? KCW : UCW;

    // config
    logic [ADDR_W-1:0] alloc_begin_reg;
    logic [ADDR_W-1:0] alloc_end_reg;
    logic [KP_W-1:0]   kern_pages_reg;

    // request
    mode_t             req_mode_reg;
    logic              req_kern_reg;
    logic [ADDR_W-1:0] req_addr_reg;

    // region state
    logic [PW-1:0]  kern_lo_reg, kern_hi_reg, user_lo_reg, user_hi_reg;
    logic [KCW-1:0] kern_cnt_reg, kern_cnt_next;
    logic [UCW-1:0] user_cnt_reg, user_cnt_next;
    logic [FW-1:0]  fill_idx_reg;
    stat_t          stat_reg, stat_next;
    logic           alloc_ok_reg, alloc_ok_next;

    // stacks
    logic [PW-1:0]  kern_mem [KERN_DEPTH];
    logic [PW-1:0]  user_mem [USER_DEPTH];
    logic [PW-1:0]  kern_rd_reg, user_rd_reg;
    logic           kern_we, user_we, kern_re, user_re;
    logic [KAW-1:0] kern_wa, kern_ra;
    logic [UAW-1:0] user_wa, user_ra;
    logic [PW-1:0]  kern_wd, user_wd;

    // output register
    logic                 m_valid_reg;
    logic [ADDR_W-1:0]    m_result_addr_reg;
    stat_t                m_status_reg;
    logic [CNT_OUT_W-1:0] m_free_count_reg;

    // bounds
    logic [PW-1:0]  bfloor;
    logic [PW:0]    bceil;
    logic [PW-1:0]  kern_span, user_span;
    logic [KCW-1:0] kern_size, kern_dec;
    logic [UCW-1:0] user_size, user_dec;
    logic [PW-1:0]  free_pn, sel_lo, sel_hi;
    logic           free_in_rgn, kern_full, user_full;
    logic           kern_fill_on, user_fill_on;
    logic [31:0]    sel_cnt32;
    logic [PW-1:0]  sel_rd;

    assign bfloor = alloc_begin_reg[ADDR_W-1:PAGE_SHIFT];
    assign bceil  = {1'b0, bfloor} + (PW+1)'(|alloc_begin_reg[PAGE_SHIFT-1:0]);

    assign kern_span = kern_hi_reg - kern_lo_reg;
    assign user_span = user_hi_reg - user_lo_reg;
    assign kern_size = (kern_hi_reg <= kern_lo_reg) ? '0 :
                       (32'(kern_span) > 32'(KERN_DEPTH)) ? KCW'(KERN_DEPTH) : KCW'(kern_span);
    assign user_size = (user_hi_reg <= user_lo_reg) ? '0 :
                       (32'(user_span) > 32'(USER_DEPTH)) ? UCW'(USER_DEPTH) : UCW'(user_span);

    assign kern_dec  = kern_cnt_reg - 1'b1;
    assign user_dec  = user_cnt_reg - 1'b1;
    assign kern_full = kern_cnt_reg >= KCW'(KERN_DEPTH);
    assign user_full = user_cnt_reg >= UCW'(USER_DEPTH);

    assign free_pn     = req_addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign sel_lo      = req_kern_reg ? kern_lo_reg : user_lo_reg;
    assign sel_hi      = req_kern_reg ? kern_hi_reg : user_hi_reg;
    assign free_in_rgn = (req_addr_reg[PAGE_SHIFT-1:0] == '0) &&
                         (free_pn >= sel_lo) && (free_pn < sel_hi);

    assign kern_fill_on = 32'(fill_idx_reg) < 32'(kern_cnt_reg);
    assign user_fill_on = 32'(fill_idx_reg) < 32'(user_cnt_reg);

    assign sel_cnt32 = req_kern_reg ? 32'(kern_cnt_reg) : 32'(user_cnt_reg);
    assign sel_rd    = req_kern_reg ? kern_rd_reg : user_rd_reg;

    assign sts.is_init   = (req_mode_reg == MODE_INIT);
    assign sts.fill_done = !kern_fill_on && !user_fill_on;
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        kern_cnt_next = kern_cnt_reg;
        user_cnt_next = user_cnt_reg;
        stat_next     = stat_reg;
        alloc_ok_next = alloc_ok_reg;
        kern_we       = 1'b0;
        user_we       = 1'b0;
        kern_re       = 1'b0;
        user_re       = 1'b0;
        kern_wa       = kern_cnt_reg[KAW-1:0];
        user_wa       = user_cnt_reg[UAW-1:0];
        kern_ra       = kern_dec[KAW-1:0];
        user_ra       = user_dec[UAW-1:0];
        kern_wd       = free_pn;
        user_wd       = free_pn;
        if (cmd.exec) begin
            stat_next     = STAT_OK;
            alloc_ok_next = 1'b0;
            unique case (req_mode_reg)
                MODE_ALLOC: begin
                    if (req_kern_reg) begin
                        if (kern_cnt_reg == '0) begin
                            stat_next = STAT_OOM;
                        end else begin
                            kern_cnt_next = kern_dec;
                            kern_re       = 1'b1;
                            alloc_ok_next = 1'b1;
                        end
                    end else begin
                        if (user_cnt_reg == '0) begin
                            stat_next = STAT_OOM;
                        end else begin
                            user_cnt_next = user_dec;
                            user_re       = 1'b1;
                            alloc_ok_next = 1'b1;
                        end
                    end
                end
                MODE_FREE: begin
                    if (!free_in_rgn) begin
                        stat_next = STAT_BAD_ADDR;
                    end else if (req_kern_reg ? kern_full : user_full) begin
                        stat_next = STAT_FULL;
                    end else if (req_kern_reg) begin
                        kern_we       = 1'b1;
                        kern_cnt_next = kern_cnt_reg + 1'b1;
                    end else begin
                        user_we       = 1'b1;
                        user_cnt_next = user_cnt_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.size) begin
            kern_cnt_next = kern_size;
            user_cnt_next = user_size;
        end
        if (cmd.fill) begin
            if (kern_fill_on) begin
                kern_we = 1'b1;
                kern_wa = fill_idx_reg[KAW-1:0];
                kern_wd = kern_lo_reg + PW'(fill_idx_reg);
            end
            if (user_fill_on) begin
                user_we = 1'b1;
                user_wa = fill_idx_reg[UAW-1:0];
                user_wd = user_lo_reg + PW'(fill_idx_reg);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_begin_reg <= '0;
            alloc_end_reg   <= '0;
            kern_pages_reg  <= KERN_PAGES_RST;
            kern_lo_reg     <= '0;
            kern_hi_reg     <= '0;
            user_lo_reg     <= '0;
            user_hi_reg     <= '0;
            kern_cnt_reg    <= '0;
            user_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ALLOC_BEGIN: alloc_begin_reg <= cfg_data;
                    CFG_ALLOC_END:   alloc_end_reg   <= cfg_data;
                    CFG_KERN_PAGES:  kern_pages_reg  <= cfg_data[KP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.exec && sts.is_init) begin
                kern_lo_reg <= sat_page((PW+2)'(bceil));
                kern_hi_reg <= sat_page((PW+2)'(bfloor) + (PW+2)'(kern_pages_reg));
                user_lo_reg <= sat_page((PW+2)'(bceil) + (PW+2)'(kern_pages_reg));
                user_hi_reg <= alloc_end_reg[ADDR_W-1:PAGE_SHIFT];
            end
            kern_cnt_reg <= kern_cnt_next;
            user_cnt_reg <= user_cnt_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_mode_reg <= mode_t'(s_mode);
            req_kern_reg <= s_in_kernel;
            req_addr_reg <= s_page_addr;
        end
        stat_reg     <= stat_next;
        alloc_ok_reg <= alloc_ok_next;
        if (cmd.size) begin
            fill_idx_reg <= '0;
        end else if (cmd.fill) begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end
        if (cmd.finish) begin
            m_result_addr_reg <= alloc_ok_reg ? {sel_rd, {PAGE_SHIFT{1'b0}}} : '0;
            m_status_reg      <= stat_reg;
            m_free_count_reg  <= sel_cnt32[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (kern_we) begin
            kern_mem[kern_wa] <= kern_wd;
        end
        if (kern_re) begin
            kern_rd_reg <= kern_mem[kern_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (user_we) begin
            user_mem[user_wa] <= user_wd;
        end
        if (user_re) begin
            user_rd_reg <= user_mem[user_ra];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_addr = m_result_addr_reg;
    assign m_status      = m_status_reg;
    assign m_free_count  = m_free_count_reg;

    `TPFA_ASSERT_IMP(a_kern_cnt_bound, aclk, aresetn, 1'b1, kern_cnt_reg <= KCW'(KERN_DEPTH))
    `TPFA_ASSERT_IMP(a_user_cnt_bound, aclk, aresetn, 1'b1, user_cnt_reg <= UCW'(USER_DEPTH))
    `TPFA_ASSERT_NXT(a_kern_pop, aclk, aresetn, cmd.exec && (req_mode_reg == MODE_ALLOC) && req_kern_reg && (kern_cnt_reg != '0), kern_cnt_reg == $past(kern_dec))
    `TPFA_ASSERT_IMP(a_finish_slot_free, aclk, aresetn, cmd.finish, !m_valid_reg || m_ready)

endmodule

// ===== sv/tpfa_ctrl.sv =====
// Controller state machine of the page allocator.
`timescale 1ns / 1ps
module tpfa_ctrl
    import tpfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_EXEC;
            S_EXEC: state_next = sts.is_init ? S_SIZE : S_FIN;
            S_SIZE: state_next = S_FILL;
            S_FILL: if (sts.fill_done) state_next = S_FIN;
            S_FIN:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_EXEC: cmd.exec   = 1'b1;
            S_SIZE: cmd.size   = 1'b1;
            S_FILL: cmd.fill   = !sts.fill_done;
            S_FIN:  cmd.finish = sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/two_region_page_free_list_allocator.sv =====
// Top level of the two-region physical page free-list allocator.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  s_*       in         s_valid / s_ready      s_mode, s_in_kernel, s_page_addr
//  m_*       out        m_valid / m_ready      m_result_addr, m_status, m_free_count
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Alloc, free and the unused mode run each request through capture, an execute step
//  (for alloc and free one stack memory access with the count update), and the load
//  of the output register. Init adds a size step and the fill sweep before that load;
//  the sweep writes one entry into each stack per cycle up to that stack's count.
//  Reset clears counts, region bounds and the output valid and restores the register
//  defaults; stack contents stay unknown, since the counts never cover an unwritten
//  entry. Configuration is always ready.
//  A result waiting on m_ready does not block the next request from starting;
//  it holds only the final load of that request's result.
//
module two_region_page_free_list_allocator
    import tpfa_pkg::*;
#(
    parameter int KERN_DEPTH = 1024,
    parameter int USER_DEPTH = 32768
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic                 s_in_kernel,
    input  logic [ADDR_W-1:0]    s_page_addr,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_result_addr,
    output logic [1:0]           m_status,
    output logic [CNT_OUT_W-1:0] m_free_count
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Config registers take a write in any cycle; the user must keep the block idle, which it does not enforce.
    assign cfg_ready = 1'b1;

    // Sequence each request: accept, execute, optional size and fill, finish.
    tpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold bounds, counts and both stacks; drive the result register.
    tpfa_dp #(
        .KERN_DEPTH (KERN_DEPTH),
        .USER_DEPTH (USER_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_mode        (s_mode),
        .s_in_kernel   (s_in_kernel),
        .s_page_addr   (s_page_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_addr (m_result_addr),
        .m_status      (m_status),
        .m_free_count  (m_free_count)
    );

endmodule
